// File: src/equirect_pixel_to_bearing_macros.svh
// Assertion macros shared by the checker of the pixel to bearing block.
`ifndef EQUIRECT_PIXEL_TO_BEARING_MACROS_SVH
`define EQUIRECT_PIXEL_TO_BEARING_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define EPTB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define EPTB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/eptb_pkg.sv
// Shared types, constants and the arctangent table of the pixel to bearing block.
package eptb_pkg;

   localparam int SUBPIXEL_BITS_DEF = 4;
   localparam int CORDIC_ITER_DEF   = 16;
   localparam int MAX_STEPS         = 24;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;

   localparam logic [31:0] GAIN_Q30 = 32'h26DD3B6A;
   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

   // register index, taken from address bit 2
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic [19:0] pixel_x;
      logic [19:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
   } rsp_type;

   // atan(2^-i) in turns, 2^32 = one turn
   function automatic logic [31:0] atan_turn(input int i);
      logic [31:0] v;
      case (i)
         0:       v = 32'h20000000;
         1:       v = 32'h12E4051E;
         2:       v = 32'h09FB385B;
         3:       v = 32'h051111D4;
         4:       v = 32'h028B0D43;
         5:       v = 32'h0145D7E1;
         6:       v = 32'h00A2F61E;
         7:       v = 32'h00517C55;
         8:       v = 32'h0028BE53;
         9:       v = 32'h00145F2F;
         10:      v = 32'h000A2F98;
         11:      v = 32'h000517CC;
         12:      v = 32'h00028BE6;
         13:      v = 32'h000145F3;
         14:      v = 32'h0000A2FA;
         15:      v = 32'h0000517D;
         16:      v = 32'h000028BE;
         17:      v = 32'h0000145F;
         18:      v = 32'h00000A30;
         19:      v = 32'h00000518;
         20:      v = 32'h0000028C;
         21:      v = 32'h00000146;
         22:      v = 32'h000000A3;
         23:      v = 32'h00000051;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

// File: src/equirect_pixel_to_bearing.sv
// Top level: equirectangular pixel position to unit bearing vector.
//
// Input channel req_*: one pixel position per item (column and row in
// subpixel units). Result channel rsp_*: one bearing (x, y, z, signed Q2.14)
// per item, in input order. Image width and height sit in two registers
// on the csr_* port (width at 0x0, height at 0x4); write them while idle.
// Takes one item per cycle while req_stall is low. From acceptance an item
// passes the centering register, the chain of divider cells (one quotient
// bit each), the fold register, the chain of CORDIC cells, the product
// register and the result register, then enters the output buffer, which
// drives rsp_valid.
// Reset empties the pipeline and the output buffer and sets both image
// dimensions to 1. A stalled receiver fills a two-entry output buffer;
// once it is full the whole chain holds and req_stall rises, so no item
// is lost. req_stall comes from a register only.
module equirect_pixel_to_bearing #(
   parameter int SUBPIXEL_BITS     = eptb_pkg::SUBPIXEL_BITS_DEF,
   parameter int CORDIC_ITERATIONS = eptb_pkg::CORDIC_ITER_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  eptb_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output eptb_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [eptb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [eptb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [eptb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import eptb_pkg::*;

   localparam int MW    = (16 + SUBPIXEL_BITS > 21) ? 16 + SUBPIXEL_BITS : 21;
   localparam int NXW   = MW + 1;
   localparam int NW    = MW + 32;
   localparam int DW    = 17 + SUBPIXEL_BITS;
   localparam int ITERS = (CORDIC_ITERATIONS > MAX_STEPS) ? MAX_STEPS : CORDIC_ITERATIONS;
   localparam int CW    = 34;
   localparam int PW    = 2 * CW;
   localparam int L     = NW + ITERS + 4;

   localparam logic signed [CW-1:0] QTR   = CW'(1) <<< 30;
   localparam logic signed [CW-1:0] HALF  = CW'(1) <<< 31;
   localparam logic signed [CW-1:0] GAIN  = CW'(GAIN_Q30);
   localparam logic signed [PW-1:0] RND46 = PW'(1) <<< 45;
   localparam logic signed [CW:0]   RND16 = (CW + 1)'(1) <<< 15;

   function automatic logic signed [15:0] sat_q14(input logic signed [47:0] v);
      logic signed [15:0] r;
      if (v > 48'sd16384)       r = ONE_Q14;
      else if (v < -48'sd16384) r = -ONE_Q14;
      else                      r = v[15:0];
      return r;
   endfunction

   // ---------------- configuration ----------------
   logic [15:0] width_ff, height_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_IMAGE_HEIGHT) ? CSR_DATA_W'(height_ff)
                                                           : CSR_DATA_W'(width_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 16'd1;
         height_ff <= 16'd1;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            REG_IMAGE_WIDTH:  width_ff  <= csr_pwdata[15:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // ---------------- flow control ----------------
   logic [1:0]   count_ff, count_in;
   logic         en, accept, push, pop;
   logic [L-1:0] vld_ff;
   rsp_type      ent0_ff, ent1_ff, res_ff;

   assign en        = (count_ff != 2'd2);
   assign req_stall = ~en;
   assign accept    = req_valid & en;
   assign push      = en & vld_ff[L-1];
   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid & ~rsp_stall;
   assign rsp_data  = ent0_ff;
   assign count_in  = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         count_ff <= 2'd0;
      end else begin
         if (en) vld_ff <= {vld_ff[L-2:0], accept};
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (push && count_ff == 2'd1) ent0_ff <= res_ff;
         else                          ent0_ff <= ent1_ff;
         if (push && count_ff == 2'd2) ent1_ff <= res_ff;
      end else if (push) begin
         if (count_ff == 2'd0) ent0_ff <= res_ff;
         else                  ent1_ff <= res_ff;
      end
   end

   // ---------------- centering ----------------
   logic [15:0]          w_eff, h_eff, side;
   logic signed [NXW-1:0] nx, ny;
   logic [NXW-1:0]       nx_neg, ny_neg;
   logic [MW-1:0]        magx_ff, magy_ff;
   logic                 negx_ff, negy_ff;
   logic [DW-1:0]        den_ff;
   logic [31:0]          half_ff;

   assign w_eff  = (width_ff == 16'd0) ? 16'd1 : width_ff;
   assign h_eff  = (height_ff == 16'd0) ? 16'd1 : height_ff;
   assign side   = (w_eff > h_eff) ? w_eff : h_eff;
   assign nx     = $signed((NXW'(req_data.pixel_x) << 1) - (NXW'(w_eff) << SUBPIXEL_BITS));
   assign ny     = $signed((NXW'(req_data.pixel_y) << 1) - (NXW'(h_eff) << SUBPIXEL_BITS));
   assign nx_neg = -nx;
   assign ny_neg = -ny;

   always_ff @(posedge clock) begin
      if (en) begin
         magx_ff <= nx[NXW-1] ? nx_neg[MW-1:0] : nx[MW-1:0];
         magy_ff <= ny[NXW-1] ? ny_neg[MW-1:0] : ny[MW-1:0];
         negx_ff <= nx[NXW-1];
         negy_ff <= ny[NXW-1];
         den_ff  <= DW'(side) << (SUBPIXEL_BITS + 1);
         half_ff <= 32'(side) << SUBPIXEL_BITS;
      end
   end

   // ---------------- divider chains ----------------
   logic [NW-1:0] xnum [0:NW];
   logic [NW-1:0] ynum [0:NW];
   logic [DW-1:0] xrem [0:NW];
   logic [DW-1:0] yrem [0:NW];
   logic [DW-1:0] xden [0:NW];
   logic [DW-1:0] yden [0:NW];
   logic [31:0]   xquo [0:NW];
   logic [31:0]   yquo [0:NW];
   logic          xneg [0:NW];
   logic          yneg [0:NW];

   assign xnum[0] = {magx_ff, half_ff};
   assign ynum[0] = {magy_ff, half_ff};
   assign xrem[0] = '0;
   assign yrem[0] = '0;
   assign xden[0] = den_ff;
   assign yden[0] = den_ff;
   assign xquo[0] = '0;
   assign yquo[0] = '0;
   assign xneg[0] = negx_ff;
   assign yneg[0] = negy_ff;

   for (genvar i = 0; i < NW; i++) begin : g_div
      eptb_div_cell #(.NW(NW), .DW(DW)) u_x (
         .clock(clock), .en(en),
         .num_in(xnum[i]), .rem_in(xrem[i]), .den_in(xden[i]),
         .quo_in(xquo[i]), .neg_in(xneg[i]),
         .num_out(xnum[i+1]), .rem_out(xrem[i+1]), .den_out(xden[i+1]),
         .quo_out(xquo[i+1]), .neg_out(xneg[i+1])
      );
      eptb_div_cell #(.NW(NW), .DW(DW)) u_y (
         .clock(clock), .en(en),
         .num_in(ynum[i]), .rem_in(yrem[i]), .den_in(yden[i]),
         .quo_in(yquo[i]), .neg_in(yneg[i]),
         .num_out(ynum[i+1]), .rem_out(yrem[i+1]), .den_out(yden[i+1]),
         .quo_out(yquo[i+1]), .neg_out(yneg[i+1])
      );
   end

   // ---------------- sign and quadrant fold ----------------
   logic [31:0]          lon_ph, lat_ph;
   logic signed [CW-1:0] lon_z, lat_z;
   logic signed [CW-1:0] lon_x [0:ITERS];
   logic signed [CW-1:0] lon_y [0:ITERS];
   logic signed [CW-1:0] lon_zz [0:ITERS];
   logic                 lon_f [0:ITERS];
   logic signed [CW-1:0] lat_x [0:ITERS];
   logic signed [CW-1:0] lat_y [0:ITERS];
   logic signed [CW-1:0] lat_zz [0:ITERS];
   logic                 lat_f [0:ITERS];
   logic signed [CW-1:0] lon_z_ff, lat_z_ff;
   logic                 lon_f_ff, lat_f_ff;

   assign lon_ph = xneg[NW] ? 32'd0 - xquo[NW] : xquo[NW];
   assign lat_ph = yneg[NW] ? 32'd0 - yquo[NW] : yquo[NW];
   assign lon_z  = CW'($signed(lon_ph));
   assign lat_z  = CW'($signed(lat_ph));

   // beyond a quarter turn: rotate by half a turn and negate the results
   always_ff @(posedge clock) begin
      if (en) begin
         if (lon_z > QTR) begin
            lon_z_ff <= lon_z - HALF;
            lon_f_ff <= 1'b1;
         end else if (lon_z < -QTR) begin
            lon_z_ff <= lon_z + HALF;
            lon_f_ff <= 1'b1;
         end else begin
            lon_z_ff <= lon_z;
            lon_f_ff <= 1'b0;
         end
         if (lat_z > QTR) begin
            lat_z_ff <= lat_z - HALF;
            lat_f_ff <= 1'b1;
         end else if (lat_z < -QTR) begin
            lat_z_ff <= lat_z + HALF;
            lat_f_ff <= 1'b1;
         end else begin
            lat_z_ff <= lat_z;
            lat_f_ff <= 1'b0;
         end
      end
   end

   // ---------------- CORDIC chains ----------------
   assign lon_x[0]  = GAIN;
   assign lon_y[0]  = '0;
   assign lon_zz[0] = lon_z_ff;
   assign lon_f[0]  = lon_f_ff;
   assign lat_x[0]  = GAIN;
   assign lat_y[0]  = '0;
   assign lat_zz[0] = lat_z_ff;
   assign lat_f[0]  = lat_f_ff;

   for (genvar i = 0; i < ITERS; i++) begin : g_cordic
      eptb_cordic_cell #(.STEP(i), .CW(CW)) u_lon (
         .clock(clock), .en(en),
         .x_in(lon_x[i]), .y_in(lon_y[i]), .z_in(lon_zz[i]), .flip_in(lon_f[i]),
         .x_out(lon_x[i+1]), .y_out(lon_y[i+1]), .z_out(lon_zz[i+1]),
         .flip_out(lon_f[i+1])
      );
      eptb_cordic_cell #(.STEP(i), .CW(CW)) u_lat (
         .clock(clock), .en(en),
         .x_in(lat_x[i]), .y_in(lat_y[i]), .z_in(lat_zz[i]), .flip_in(lat_f[i]),
         .x_out(lat_x[i+1]), .y_out(lat_y[i+1]), .z_out(lat_zz[i+1]),
         .flip_out(lat_f[i+1])
      );
   end

   // ---------------- products and rounding ----------------
   logic signed [PW-1:0] px_ff, pz_ff, rx, rz;
   logic signed [CW-1:0] sy_ff;
   logic signed [CW:0]   ry;
   logic                 fx_ff, fz_ff, fy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= PW'(lat_x[ITERS]) * PW'(lon_y[ITERS]);
         pz_ff <= PW'(lat_x[ITERS]) * PW'(lon_x[ITERS]);
         sy_ff <= lat_y[ITERS];
         fx_ff <= lat_f[ITERS] ^ lon_f[ITERS];
         fz_ff <= lat_f[ITERS] ^ lon_f[ITERS];
         fy_ff <= lat_f[ITERS];
      end
   end

   // negation folded into the rounding add
   assign rx = fx_ff ? RND46 - px_ff : px_ff + RND46;
   assign rz = fz_ff ? RND46 - pz_ff : pz_ff + RND46;
   assign ry = fy_ff ? (CW + 1)'(sy_ff) + RND16 : RND16 - (CW + 1)'(sy_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff.dir_x <= sat_q14(48'(rx >>> 46));
         res_ff.dir_y <= sat_q14(48'(ry >>> 16));
         res_ff.dir_z <= sat_q14(48'(rz >>> 46));
      end
   end
endmodule

// File: src/eptb_div_cell.sv
// One restoring division cell: takes one numerator bit, yields one quotient bit.
module eptb_div_cell #(
   parameter int NW = 53,
   parameter int DW = 21
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num_in,
   input  logic [DW-1:0] rem_in,
   input  logic [DW-1:0] den_in,
   input  logic [31:0]   quo_in,
   input  logic          neg_in,
   output logic [NW-1:0] num_out,
   output logic [DW-1:0] rem_out,
   output logic [DW-1:0] den_out,
   output logic [31:0]   quo_out,
   output logic          neg_out
);
   logic [NW-1:0] num_ff;
   logic [DW-1:0] rem_ff, den_ff, rem_in_next;
   logic [31:0]   quo_ff;
   logic          neg_ff, ge;
   logic [DW:0]   trial, diff;

   assign trial = {rem_in, num_in[NW-1]};
   assign diff  = trial - {1'b0, den_in};
   assign ge    = trial >= {1'b0, den_in};
   // remainder stays below the divisor, so DW bits hold it
   assign rem_in_next = ge ? diff[DW-1:0] : trial[DW-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= {num_in[NW-2:0], 1'b0};
         rem_ff <= rem_in_next;
         den_ff <= den_in;
         quo_ff <= {quo_in[30:0], ge};
         neg_ff <= neg_in;
      end
   end

   assign num_out = num_ff;
   assign rem_out = rem_ff;
   assign den_out = den_ff;
   assign quo_out = quo_ff;
   assign neg_out = neg_ff;
endmodule

// File: src/eptb_cordic_cell.sv
// One rotation-mode CORDIC cell with a fixed shift and arctangent.
module eptb_cordic_cell #(
   parameter int STEP = 0,
   parameter int CW   = 34
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [CW-1:0] x_in,
   input  logic signed [CW-1:0] y_in,
   input  logic signed [CW-1:0] z_in,
   input  logic                 flip_in,
   output logic signed [CW-1:0] x_out,
   output logic signed [CW-1:0] y_out,
   output logic signed [CW-1:0] z_out,
   output logic                 flip_out
);
   import eptb_pkg::*;

   localparam logic signed [CW-1:0] ATAN = CW'(atan_turn(STEP));

   logic signed [CW-1:0] dx, dy, x_ff, y_ff, z_ff;
   logic                 flip_ff;

   assign dx = y_in >>> STEP;
   assign dy = x_in >>> STEP;

   always_ff @(posedge clock) begin
      if (en) begin
         if (!z_in[CW-1]) begin
            x_ff <= x_in - dx;
            y_ff <= y_in + dy;
            z_ff <= z_in - ATAN;
         end else begin
            x_ff <= x_in + dx;
            y_ff <= y_in - dy;
            z_ff <= z_in + ATAN;
         end
         flip_ff <= flip_in;
      end
   end

   assign x_out    = x_ff;
   assign y_out    = y_ff;
   assign z_out    = z_ff;
   assign flip_out = flip_ff;
endmodule

// File: src/eptb_checker.sv
// Port-level checker for the pixel to bearing block, bound to the top level.
`include "equirect_pixel_to_bearing_macros.svh"

module eptb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input eptb_pkg::req_type               req_data,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input eptb_pkg::rsp_type               rsp_data,
   input logic                            csr_psel,
   input logic                            csr_penable,
   input logic                            csr_pwrite,
   input logic [eptb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [eptb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input logic [eptb_pkg::CSR_DATA_W-1:0] csr_prdata,
   input logic                            csr_pready
);
   `EPTB_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> (!rsp_valid && !req_stall), "not empty after reset")
   `EPTB_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled item changed")
   `EPTB_ASSERT(a_range, clock, reset, rsp_valid |-> (rsp_data.dir_x <= 16'sd16384 && rsp_data.dir_x >= -16'sd16384 && rsp_data.dir_y <= 16'sd16384 && rsp_data.dir_y >= -16'sd16384 && rsp_data.dir_z <= 16'sd16384 && rsp_data.dir_z >= -16'sd16384), "component out of range")
   `EPTB_ASSERT(a_no_stall_idle, clock, reset, !rsp_valid |=> !req_stall, "input stalled with empty output")
   `EPTB_ASSERT_ALWAYS(a_pready, clock, csr_pready, "pready low")
endmodule

bind equirect_pixel_to_bearing eptb_checker u_eptb_checker (.*);
